FILE: hdl/ntmd_pkg.sv
// ----------------------------------------------------------------------------
// ntmd_pkg
// Types and constants shared by the nearest-to-mean denoise filter.
// ----------------------------------------------------------------------------
package ntmd_pkg;

   localparam int NB_COUNT     = 13;
   localparam int NB_INNER     = 9;
   localparam int QUEUE_DEPTH  = 4;
   localparam int MEAN_SHIFT   = 17;
   localparam logic [13:0] RECIP9  = 14'd14564;
   localparam logic [13:0] RECIP13 = 14'd10083;

   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [10:0] WIDTH_RESET  = 11'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;

   // Neighbor slots in order: 3x3 block rows top to bottom, then up2,
   // down2 (the incoming pixel), left2, right2.
   localparam int NB_CENTER = 4;
   localparam int NB_CUR    = 10;

   typedef struct packed {
      logic [7:0] pix_c2;
      logic [7:0] pix_c1;
      logic [7:0] pix_c0;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_c2;
      logic [7:0]  out_c1;
      logic [7:0]  out_c0;
      logic [11:0] out_row;
      logic [9:0]  out_col;
      logic        was_filtered;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [NB_COUNT-1:0][23:0] pix;
      logic        emit_a;
      logic        inner;
      logic        emit_b;
      logic [11:0] row_a;
      logic [11:0] row_b;
      logic [9:0]  col;
   } work_type;

endpackage

FILE: hdl/nearest_to_mean_denoise_filter.sv
// ----------------------------------------------------------------------------
// nearest_to_mean_denoise_filter
// Streaming nearest-to-mean denoise filter over a four-line store.
// ----------------------------------------------------------------------------
// The block takes one pixel transfer per clock while its queue has room. When
// pixel (r,c) arrives the pixel (r-2,c) leaves, filtered if it lies two or
// more from every edge and passed through otherwise; in the bottom two rows
// the incoming pixel also leaves as a passthrough, so such a pixel makes two
// result transfers through the single result port. The line store is one
// memory bank per line with one read and one write port, which sets the
// one-pixel-per-clock input rate. Frame size registers may only change while
// idle.
module nearest_to_mean_denoise_filter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ntmd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ntmd_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [12:0]       csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH+1);
   localparam int RW = $clog2(MAX_HEIGHT+1);

   logic [10:0] frame_width_ff;
   logic [12:0] frame_height_ff;
   logic [CW-1:0] width_eff;
   logic [RW-1:0] height_eff;
   logic accept, q_full, q_empty, q_pop;
   ntmd_pkg::work_type work, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= ntmd_pkg::WIDTH_RESET;
         frame_height_ff <= ntmd_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         if (csr_index == ntmd_pkg::REG_FRAME_WIDTH) begin
            frame_width_ff <= csr_wdata[10:0];
         end
         if (csr_index == ntmd_pkg::REG_FRAME_HEIGHT) begin
            frame_height_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      if (frame_width_ff < 11'd5) begin
         width_eff = CW'(5);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         width_eff = CW'(MAX_WIDTH);
      end else begin
         width_eff = CW'(frame_width_ff);
      end
      if (frame_height_ff < 13'd5) begin
         height_eff = RW'(5);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         height_eff = RW'(MAX_HEIGHT);
      end else begin
         height_eff = RW'(frame_height_ff);
      end
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   ntmd_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pixel     (req_data),
      .width_eff (width_eff),
      .height_eff(height_eff),
      .work      (work)
   );

   ntmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_data(work),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   ntmd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

FILE: hdl/ntmd_queue.sv
// ----------------------------------------------------------------------------
// ntmd_queue
// Small register queue between the front end and the filter pipeline.
// ----------------------------------------------------------------------------
module ntmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ntmd_pkg::work_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output ntmd_pkg::work_type head
);

   localparam int PW = $clog2(ntmd_pkg::QUEUE_DEPTH);

   ntmd_pkg::work_type entry_ff [ntmd_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_pop;

   assign full   = (count_ff == (PW+1)'(ntmd_pkg::QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign head   = entry_ff[rp_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wp_in    = push ? wp_ff + 1'b1 : wp_ff;
      rp_in    = do_pop ? rp_ff + 1'b1 : rp_ff;
      count_in = count_ff + (PW+1)'(push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wp_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/ntmd_front.sv
// ----------------------------------------------------------------------------
// ntmd_front
// Position counters, four-line store and window assembly for each pixel.
// ----------------------------------------------------------------------------
module ntmd_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  ntmd_pkg::req_type                  pixel,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]     width_eff,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]    height_eff,
   output ntmd_pkg::work_type                 work
);

   localparam int CW = $clog2(MAX_WIDTH+1);
   localparam int RW = $clog2(MAX_HEIGHT+1);
   localparam int AW = $clog2(MAX_WIDTH);

   logic [CW-1:0] col_ff, col_in, col_pre, raddr_full;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] raddr, waddr;
   logic [23:0]   cur;
   logic [3:0][23:0] rd_ff;
   logic [3:0][23:0] win_ff [4];
   logic [1:0] b1, b2, b3, b4;

   assign cur   = {pixel.pix_c2, pixel.pix_c1, pixel.pix_c0};
   assign waddr = AW'(col_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff + 1'b1 >= width_eff) begin
            col_in = '0;
            row_in = (row_ff + 1'b1 >= height_eff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      col_pre    = col_in + CW'(2);
      raddr_full = (col_pre >= width_eff) ? col_pre - width_eff : col_pre;
      raddr      = AW'(raddr_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      logic [23:0] mem [MAX_WIDTH];
      always_ff @(posedge clock) begin
         if (accept && row_ff[1:0] == 2'(g)) begin
            mem[waddr] <= cur;
         end
         rd_ff[g] <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff[0] <= rd_ff;
         win_ff[1] <= win_ff[0];
         win_ff[2] <= win_ff[1];
         win_ff[3] <= win_ff[2];
      end
   end

   always_comb begin
      b1 = row_ff[1:0] - 2'd1;
      b2 = row_ff[1:0] - 2'd2;
      b3 = row_ff[1:0] - 2'd3;
      b4 = row_ff[1:0];
      work.pix[0]  = win_ff[2][b3];
      work.pix[1]  = win_ff[1][b3];
      work.pix[2]  = win_ff[0][b3];
      work.pix[3]  = win_ff[2][b2];
      work.pix[4]  = win_ff[1][b2];
      work.pix[5]  = win_ff[0][b2];
      work.pix[6]  = win_ff[2][b1];
      work.pix[7]  = win_ff[1][b1];
      work.pix[8]  = win_ff[0][b1];
      work.pix[9]  = win_ff[1][b4];
      work.pix[10] = cur;
      work.pix[11] = win_ff[3][b2];
      work.pix[12] = rd_ff[b2];
      work.emit_a  = (row_ff >= RW'(2));
      work.inner   = (row_ff >= RW'(4)) && (col_ff >= CW'(2))
                     && (32'(col_ff) + 3 <= 32'(width_eff));
      work.emit_b  = (32'(row_ff) + 2 >= 32'(height_eff));
      work.row_a   = 12'(row_ff - RW'(2));
      work.row_b   = 12'(row_ff);
      work.col     = 10'(col_ff);
   end

endmodule

FILE: hdl/ntmd_back.sv
// ----------------------------------------------------------------------------
// ntmd_back
// Filter pipeline: sums, means, distances, nearest picks and result output.
// ----------------------------------------------------------------------------
module ntmd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  ntmd_pkg::work_type q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ntmd_pkg::rsp_type  rsp_data
);

   function automatic logic [3:0] first_min(input logic [15:0][9:0] d);
      logic [7:0][9:0] d1;
      logic [7:0][3:0] i1;
      logic [3:0][9:0] d2;
      logic [3:0][3:0] i2;
      logic [1:0][9:0] d3;
      logic [1:0][3:0] i3;
      for (int k = 0; k < 8; k++) begin
         if (d[2*k] <= d[2*k+1]) begin
            d1[k] = d[2*k];
            i1[k] = 4'(2*k);
         end else begin
            d1[k] = d[2*k+1];
            i1[k] = 4'(2*k+1);
         end
      end
      for (int k = 0; k < 4; k++) begin
         if (d1[2*k] <= d1[2*k+1]) begin
            d2[k] = d1[2*k];
            i2[k] = i1[2*k];
         end else begin
            d2[k] = d1[2*k+1];
            i2[k] = i1[2*k+1];
         end
      end
      for (int k = 0; k < 2; k++) begin
         if (d2[2*k] <= d2[2*k+1]) begin
            d3[k] = d2[2*k];
            i3[k] = i2[2*k];
         end else begin
            d3[k] = d2[2*k+1];
            i3[k] = i2[2*k+1];
         end
      end
      return (d3[0] <= d3[1]) ? i3[0] : i3[1];
   endfunction

   logic en;

   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   ntmd_pkg::work_type s1_ff, s2_ff, s3_ff, s4_ff;
   logic [2:0][11:0] sum9_ff, sum13_ff, sum9_in, sum13_in;
   logic [2:0][7:0]  m9_ff, m13_ff, m9_in, m13_in;
   logic [15:0][9:0] d9_ff, d13_ff, d9_in, d13_in;
   logic [23:0] pa_ff, pb_ff, pa_in, pb_in;
   logic [26:0] prod9, prod13;
   logic [9:0]  l1_dist;
   logic [7:0]  v;

   logic        out_v_ff, phase_ff;
   logic        has_a_ff, has_b_ff, filt_ff;
   logic [23:0] val_a_ff, val_b_ff, val_a_in;
   logic [11:0] row_a_ff, row_b_ff;
   logic [9:0]  col_ff;
   logic        sel_b, last;
   logic [8:0]  avg;

   assign sel_b = !has_a_ff || phase_ff;
   assign last  = sel_b || !has_b_ff;
   assign en    = !out_v_ff || (rsp_ready && last);
   assign q_pop = en;

   always_comb begin
      sum9_in  = '0;
      sum13_in = '0;
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < ntmd_pkg::NB_INNER; k++) begin
            sum9_in[ch] = sum9_in[ch] + 12'(q_head.pix[k][8*ch +: 8]);
         end
         sum13_in[ch] = sum9_in[ch];
         for (int k = ntmd_pkg::NB_INNER; k < ntmd_pkg::NB_COUNT; k++) begin
            sum13_in[ch] = sum13_in[ch] + 12'(q_head.pix[k][8*ch +: 8]);
         end
      end
   end

   always_comb begin
      m9_in  = '0;
      m13_in = '0;
      prod9  = '0;
      prod13 = '0;
      for (int ch = 0; ch < 3; ch++) begin
         prod9      = 27'(sum9_ff[ch]) * 27'(ntmd_pkg::RECIP9);
         prod13     = 27'(sum13_ff[ch]) * 27'(ntmd_pkg::RECIP13);
         m9_in[ch]  = prod9[ntmd_pkg::MEAN_SHIFT +: 8];
         m13_in[ch] = prod13[ntmd_pkg::MEAN_SHIFT +: 8];
      end
   end

   always_comb begin
      d9_in   = '1;
      d13_in  = '1;
      l1_dist = '0;
      v       = '0;
      for (int k = 0; k < ntmd_pkg::NB_COUNT; k++) begin
         l1_dist = '0;
         for (int ch = 0; ch < 3; ch++) begin
            v       = s2_ff.pix[k][8*ch +: 8];
            l1_dist = l1_dist
                      + 10'((m13_ff[ch] > v) ? m13_ff[ch] - v : v - m13_ff[ch]);
         end
         d13_in[k] = l1_dist;
         l1_dist = '0;
         for (int ch = 0; ch < 3; ch++) begin
            v       = s2_ff.pix[k][8*ch +: 8];
            l1_dist = l1_dist
                      + 10'((m9_ff[ch] > v) ? m9_ff[ch] - v : v - m9_ff[ch]);
         end
         if (k < ntmd_pkg::NB_INNER) begin
            d9_in[k] = l1_dist;
         end
      end
   end

   always_comb begin
      pa_in = s3_ff.pix[first_min(d9_ff)];
      pb_in = s3_ff.pix[first_min(d13_ff)];
   end

   always_comb begin
      val_a_in = s4_ff.pix[ntmd_pkg::NB_CENTER];
      avg      = '0;
      if (s4_ff.inner) begin
         for (int ch = 0; ch < 3; ch++) begin
            avg = 9'(pa_ff[8*ch +: 8]) + 9'(pb_ff[8*ch +: 8]);
            val_a_in[8*ch +: 8] = avg[8:1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff  <= !q_empty;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         s4_v_ff  <= s3_v_ff;
         out_v_ff <= s4_v_ff && (s4_ff.emit_a || s4_ff.emit_b);
         phase_ff <= 1'b0;
      end else if (out_v_ff && rsp_ready) begin
         phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff    <= q_head;
         sum9_ff  <= sum9_in;
         sum13_ff <= sum13_in;
         s2_ff    <= s1_ff;
         m9_ff    <= m9_in;
         m13_ff   <= m13_in;
         s3_ff    <= s2_ff;
         d9_ff    <= d9_in;
         d13_ff   <= d13_in;
         s4_ff    <= s3_ff;
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         has_a_ff <= s4_ff.emit_a;
         has_b_ff <= s4_ff.emit_b;
         filt_ff  <= s4_ff.inner;
         val_a_ff <= val_a_in;
         val_b_ff <= s4_ff.pix[ntmd_pkg::NB_CUR];
         row_a_ff <= s4_ff.row_a;
         row_b_ff <= s4_ff.row_b;
         col_ff   <= s4_ff.col;
      end
   end

   always_comb begin
      rsp_valid             = out_v_ff;
      rsp_data.out_c0       = sel_b ? val_b_ff[7:0]   : val_a_ff[7:0];
      rsp_data.out_c1       = sel_b ? val_b_ff[15:8]  : val_a_ff[15:8];
      rsp_data.out_c2       = sel_b ? val_b_ff[23:16] : val_a_ff[23:16];
      rsp_data.out_row      = sel_b ? row_b_ff : row_a_ff;
      rsp_data.out_col      = col_ff;
      rsp_data.was_filtered = sel_b ? 1'b0 : filt_ff;
      rsp_data.last_of_run  = last;
   end

endmodule
